### hdl/dies_pkg.sv
// ----------------------------------------------------------------------------
// dies_pkg
// Shared types and constants of the dual inverter enable sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dies_pkg;

   localparam int IdWidth    = 11;
   localparam int ByteWidth  = 8;
   localparam int WordWidth  = 16;
   localparam int CsrIdxWidth = 3;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [IdWidth-1:0] ID_STATUS_ONE = 11'h283;
   localparam logic [IdWidth-1:0] ID_STATUS_TWO = 11'h284;
   localparam logic [IdWidth-1:0] ID_HEARD_ONE  = 11'h285;
   localparam logic [IdWidth-1:0] ID_HEARD_TWO  = 11'h286;

   localparam logic [ByteWidth-1:0] BIT_READY   = 8'h01;
   localparam logic [ByteWidth-1:0] BIT_FAULT   = 8'h02;
   localparam logic [ByteWidth-1:0] BIT_ACK_DC  = 8'h08;
   localparam logic [ByteWidth-1:0] BIT_DC_ON   = 8'h10;
   localparam logic [ByteWidth-1:0] BIT_ACK_INV = 8'h20;
   localparam logic [ByteWidth-1:0] BIT_INV_ON  = 8'h40;

   localparam logic [ByteWidth-1:0] CMD_ERR_RESET = 8'h08;
   localparam logic [ByteWidth-1:0] CMD_DC_ON     = 8'h02;
   localparam logic [ByteWidth-1:0] CMD_ENA_INV   = 8'h05;

   localparam logic [CsrIdxWidth-1:0] CSR_FIRST_ID    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SECOND_ID   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FIRST_SPEED = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SECOND_SPEED = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TORQUE_POS  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_TORQUE_NEG  = 3'd5;

   typedef enum logic [10:0] {
      ST_RESET_ERR  = 11'b000_0000_0001,
      ST_WAIT_READY = 11'b000_0000_0010,
      ST_SET_DC     = 11'b000_0000_0100,
      ST_WAIT_DC    = 11'b000_0000_1000,
      ST_ACK_DC     = 11'b000_0001_0000,
      ST_CLEAR_PTS  = 11'b000_0010_0000,
      ST_SET_ENA    = 11'b000_0100_0000,
      ST_WAIT_INV   = 11'b000_1000_0000,
      ST_ACK_INV    = 11'b001_0000_0000,
      ST_RUN        = 11'b010_0000_0000,
      ST_ERROR      = 11'b100_0000_0000
   } seq_state_type;

   typedef struct packed {
      logic [ByteWidth-1:0] control_byte;
      logic                 loaded;
   } tick_type;

endpackage

`default_nettype wire

### hdl/dies_front.sv
// ----------------------------------------------------------------------------
// dies_front
// Accepts requests, tracks inverter status, runs the start-up sequence and
// hands one record per tick to the transmit queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dies_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_fire,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [dies_pkg::IdWidth-1:0]  req_rx_frame_id,
   input  wire logic [dies_pkg::ByteWidth-1:0] req_status_byte,
   output      logic                          push,
   output      dies_pkg::tick_type            push_data
);

   dies_pkg::seq_state_type state_ff, state_in, step_state;
   logic [dies_pkg::ByteWidth-1:0] first_status_ff, first_status_in;
   logic [dies_pkg::ByteWidth-1:0] second_status_ff, second_status_in;
   logic first_heard_ff, first_heard_in;
   logic second_heard_ff, second_heard_in;
   logic [dies_pkg::ByteWidth-1:0] command_ff, command_in, step_command;
   logic loaded_ff, loaded_in, step_loaded;
   logic fault;

   function automatic logic both_have(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] mask);
      both_have = ((a & mask) != 8'd0) && ((b & mask) != 8'd0);
   endfunction

   assign fault = ((first_status_ff | second_status_ff) & dies_pkg::BIT_FAULT) != 8'd0;

   always_comb begin
      step_state   = state_ff;
      step_command = command_ff;
      step_loaded  = loaded_ff;
      case (state_ff)
         dies_pkg::ST_RESET_ERR: begin
            step_command = dies_pkg::CMD_ERR_RESET;
            step_loaded  = 1'b0;
            if (first_heard_ff && second_heard_ff && !fault) begin
               step_state = dies_pkg::ST_WAIT_READY;
            end
         end
         dies_pkg::ST_WAIT_READY: begin
            if (both_have(first_status_ff, second_status_ff, dies_pkg::BIT_READY)) begin
               step_state = dies_pkg::ST_SET_DC;
            end
         end
         dies_pkg::ST_SET_DC: begin
            step_command = dies_pkg::CMD_DC_ON;
            step_state   = dies_pkg::ST_WAIT_DC;
         end
         dies_pkg::ST_WAIT_DC: begin
            step_state = both_have(first_status_ff, second_status_ff, dies_pkg::BIT_DC_ON) ?
                         dies_pkg::ST_ACK_DC : dies_pkg::ST_SET_DC;
         end
         dies_pkg::ST_ACK_DC: begin
            step_state = both_have(first_status_ff, second_status_ff, dies_pkg::BIT_ACK_DC) ?
                         dies_pkg::ST_CLEAR_PTS : dies_pkg::ST_WAIT_DC;
         end
         dies_pkg::ST_CLEAR_PTS: begin
            step_state = dies_pkg::ST_SET_ENA;
         end
         dies_pkg::ST_SET_ENA: begin
            step_command = command_ff | dies_pkg::CMD_ENA_INV;
            step_state   = dies_pkg::ST_WAIT_INV;
         end
         dies_pkg::ST_WAIT_INV: begin
            step_state = both_have(first_status_ff, second_status_ff, dies_pkg::BIT_INV_ON) ?
                         dies_pkg::ST_ACK_INV : dies_pkg::ST_SET_ENA;
         end
         dies_pkg::ST_ACK_INV: begin
            step_state = both_have(first_status_ff, second_status_ff, dies_pkg::BIT_ACK_INV) ?
                         dies_pkg::ST_RUN : dies_pkg::ST_WAIT_INV;
         end
         dies_pkg::ST_ERROR: begin
            step_state = dies_pkg::ST_RESET_ERR;
         end
         default: begin
            step_state = state_ff;
         end
      endcase
      // force error on a fault, except in reset and run
      if (fault && step_state != dies_pkg::ST_RESET_ERR && step_state != dies_pkg::ST_RUN) begin
         step_state = dies_pkg::ST_ERROR;
      end
   end

   always_comb begin
      state_in         = state_ff;
      first_status_in  = first_status_ff;
      second_status_in = second_status_ff;
      first_heard_in   = first_heard_ff;
      second_heard_in  = second_heard_ff;
      command_in       = command_ff;
      loaded_in        = loaded_ff;
      push             = 1'b0;
      if (req_fire) begin
         case (req_opcode)
            dies_pkg::OP_FRAME: begin
               case (req_rx_frame_id)
                  dies_pkg::ID_STATUS_ONE: begin
                     first_heard_in  = 1'b1;
                     first_status_in = req_status_byte;
                  end
                  dies_pkg::ID_HEARD_ONE: begin
                     first_heard_in = 1'b1;
                  end
                  dies_pkg::ID_STATUS_TWO: begin
                     second_heard_in  = 1'b1;
                     second_status_in = req_status_byte;
                  end
                  dies_pkg::ID_HEARD_TWO: begin
                     second_heard_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            dies_pkg::OP_STEP: begin
               state_in   = step_state;
               command_in = step_command;
               loaded_in  = step_loaded;
            end
            dies_pkg::OP_TICK: begin
               loaded_in = loaded_ff | (state_ff == dies_pkg::ST_RUN);
               push      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign push_data.control_byte = command_ff;
   assign push_data.loaded       = loaded_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= dies_pkg::ST_RESET_ERR;
         first_status_ff  <= '0;
         second_status_ff <= '0;
         first_heard_ff   <= 1'b0;
         second_heard_ff  <= 1'b0;
         command_ff       <= '0;
         loaded_ff        <= 1'b0;
      end else begin
         state_ff         <= state_in;
         first_status_ff  <= first_status_in;
         second_status_ff <= second_status_in;
         first_heard_ff   <= first_heard_in;
         second_heard_ff  <= second_heard_in;
         command_ff       <= command_in;
         loaded_ff        <= loaded_in;
      end
   end

endmodule

`default_nettype wire

### hdl/dies_queue.sv
// ----------------------------------------------------------------------------
// dies_queue
// Short first-in first-out queue of tick records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dies_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dies_pkg::tick_type push_data,
   input  wire logic               pop,
   output      dies_pkg::tick_type pop_data,
   output      logic               full,
   output      logic               empty
);

   dies_pkg::tick_type entry_ff [dies_pkg::QueueDepth];
   logic [dies_pkg::QueuePtrWidth-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [dies_pkg::QueueCntWidth-1:0] count_ff, count_in;

   assign full     = count_ff == dies_pkg::QueueCntWidth'(dies_pkg::QueueDepth);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + dies_pkg::QueuePtrWidth'(1);
      end
      if (pop) begin
         head_in = head_ff + dies_pkg::QueuePtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + dies_pkg::QueueCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - dies_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/dies_back.sv
// ----------------------------------------------------------------------------
// dies_back
// Holds the command registers and turns each tick record into two command
// frames through a registered response stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dies_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [dies_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [dies_pkg::WordWidth-1:0]    csr_write_data,
   input  wire dies_pkg::tick_type                pop_data,
   input  wire logic                              empty,
   output      logic                              pop,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [dies_pkg::IdWidth-1:0]      rsp_tx_frame_id,
   output      logic [dies_pkg::ByteWidth-1:0]    rsp_control_byte,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_speed_word,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_torque_pos_word,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_torque_neg_word,
   output      logic                              rsp_last
);

   logic [dies_pkg::IdWidth-1:0]   first_id_ff, second_id_ff;
   logic [dies_pkg::WordWidth-1:0] first_speed_ff, second_speed_ff;
   logic [dies_pkg::WordWidth-1:0] torque_pos_ff, torque_neg_ff;

   dies_pkg::tick_type held_ff, held_in;
   logic second_pend_ff, second_pend_in;
   logic valid_ff, valid_in;
   logic [dies_pkg::IdWidth-1:0]   id_ff, id_in;
   logic [dies_pkg::ByteWidth-1:0] ctrl_ff, ctrl_in;
   logic [dies_pkg::WordWidth-1:0] speed_ff, speed_in, tpos_ff, tpos_in, tneg_ff, tneg_in;
   logic last_ff, last_in;
   logic slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff     <= 11'h300;
         second_id_ff    <= 11'h400;
         first_speed_ff  <= 16'd20;
         second_speed_ff <= 16'd300;
         torque_pos_ff   <= 16'd1000;
         torque_neg_ff   <= 16'hFC18;
      end else if (csr_write_enable) begin
         case (csr_index)
            dies_pkg::CSR_FIRST_ID:     first_id_ff     <= csr_write_data[dies_pkg::IdWidth-1:0];
            dies_pkg::CSR_SECOND_ID:    second_id_ff    <= csr_write_data[dies_pkg::IdWidth-1:0];
            dies_pkg::CSR_FIRST_SPEED:  first_speed_ff  <= csr_write_data;
            dies_pkg::CSR_SECOND_SPEED: second_speed_ff <= csr_write_data;
            dies_pkg::CSR_TORQUE_POS:   torque_pos_ff   <= csr_write_data;
            dies_pkg::CSR_TORQUE_NEG:   torque_neg_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      held_in        = held_ff;
      second_pend_in = second_pend_ff;
      valid_in       = valid_ff;
      id_in          = id_ff;
      ctrl_in        = ctrl_ff;
      speed_in       = speed_ff;
      tpos_in        = tpos_ff;
      tneg_in        = tneg_ff;
      last_in        = last_ff;
      pop            = 1'b0;
      if (slot_free) begin
         if (second_pend_ff) begin
            valid_in       = 1'b1;
            second_pend_in = 1'b0;
            id_in          = second_id_ff;
            ctrl_in        = held_ff.control_byte;
            speed_in       = held_ff.loaded ? second_speed_ff : '0;
            tpos_in        = held_ff.loaded ? torque_pos_ff : '0;
            tneg_in        = held_ff.loaded ? torque_neg_ff : '0;
            last_in        = 1'b1;
         end else if (!empty) begin
            pop            = 1'b1;
            valid_in       = 1'b1;
            second_pend_in = 1'b1;
            held_in        = pop_data;
            id_in          = first_id_ff;
            ctrl_in        = pop_data.control_byte;
            speed_in       = pop_data.loaded ? first_speed_ff : '0;
            tpos_in        = pop_data.loaded ? torque_pos_ff : '0;
            tneg_in        = pop_data.loaded ? torque_neg_ff : '0;
            last_in        = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         second_pend_ff <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         second_pend_ff <= second_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      id_ff    <= id_in;
      ctrl_ff  <= ctrl_in;
      speed_ff <= speed_in;
      tpos_ff  <= tpos_in;
      tneg_ff  <= tneg_in;
      last_ff  <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_tx_frame_id     = id_ff;
   assign rsp_control_byte    = ctrl_ff;
   assign rsp_speed_word      = speed_ff;
   assign rsp_torque_pos_word = tpos_ff;
   assign rsp_torque_neg_word = tneg_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire

### hdl/dual_inverter_enable_sequencer_core.sv
// ----------------------------------------------------------------------------
// dual_inverter_enable_sequencer_core
// Start-up sequencer for two inverters: status tracking and sequence in the
// front, command frame output in the back, a tick queue in between.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   opcode, rx_frame_id, status_byte
//   rsp       out        rsp_valid/rsp_stall   tx_frame_id .. last, two per tick
//   csr       in         csr_write_enable      csr_index, csr_write_data
//
// One request per cycle is accepted unless req_stall is high; a tick yields two responses.
// The output stage sets the sustained rate: one response per cycle while rsp_stall is low.
// Only a tick stalls, and only while the four-entry tick queue is full.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_inverter_enable_sequencer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [1:0]                        req_opcode,
   input  wire logic [dies_pkg::IdWidth-1:0]      req_rx_frame_id,
   input  wire logic [dies_pkg::ByteWidth-1:0]    req_status_byte,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [dies_pkg::IdWidth-1:0]      rsp_tx_frame_id,
   output      logic [dies_pkg::ByteWidth-1:0]    rsp_control_byte,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_speed_word,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_torque_pos_word,
   output      logic signed [dies_pkg::WordWidth-1:0] rsp_torque_neg_word,
   output      logic                              rsp_last,
   input  wire logic                              csr_write_enable,
   input  wire logic [dies_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [dies_pkg::WordWidth-1:0]    csr_write_data
);

   logic req_fire, push, pop, full, empty;
   dies_pkg::tick_type push_data, pop_data;

   assign req_stall = full && (req_opcode == dies_pkg::OP_TICK);
   assign req_fire  = req_valid && !req_stall;

   dies_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_opcode      (req_opcode),
      .req_rx_frame_id (req_rx_frame_id),
      .req_status_byte (req_status_byte),
      .push            (push),
      .push_data       (push_data)
   );

   dies_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   dies_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .pop_data            (pop_data),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tx_frame_id     (rsp_tx_frame_id),
      .rsp_control_byte    (rsp_control_byte),
      .rsp_speed_word      (rsp_speed_word),
      .rsp_torque_pos_word (rsp_torque_pos_word),
      .rsp_torque_neg_word (rsp_torque_neg_word),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
